/* rtl/wdt_pkg.sv */
// Shared types, codes and constants of the watchdog channel table.
package wdt_pkg;

    localparam int WDT_SLOTS       = 8;
    localparam int WDT_MAX_RESULTS = 8;
    localparam int WDT_NREP_W      = $clog2(WDT_MAX_RESULTS + 1);

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_ADD    = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_KICK   = 2'd3;

    localparam logic [1:0] KIND_DISABLED = 2'd0;

    localparam logic RES_ACK    = 1'b0;
    localparam logic RES_EXPIRY = 1'b1;

    // One channel as held by a cell
    typedef struct packed {
        logic        occ;
        logic [31:0] id;
        logic [1:0]  kind;
        logic [31:0] tmo;
        logic [31:0] stamp;
    } wdt_entry_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic        add;
        logic        kick;
        logic [31:0] id;
        logic [1:0]  kind;
        logic [31:0] tmo;
        logic [31:0] now;
    } wdt_ctl_t;

endpackage

/* rtl/wdt_cell.sv */
// One table cell: holds a channel, loads from its neighbour, takes adds and kicks.
module wdt_cell
    import wdt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  wdt_ctl_t   ctl,
    input  logic       load,
    input  logic       add_here,
    input  wdt_entry_t nxt_in,
    output wdt_entry_t q,
    output logic       match
);

    wdt_entry_t q_reg;
    wdt_entry_t q_next;

    assign match = q_reg.occ && (q_reg.id == ctl.id);
    assign q     = q_reg;

    always_comb begin
        q_next = q_reg;
        if (load) begin
            q_next = nxt_in;
        end else if (ctl.add && add_here) begin
            q_next.occ   = 1'b1;
            q_next.id    = ctl.id;
            q_next.kind  = ctl.kind;
            q_next.tmo   = ctl.tmo;
            q_next.stamp = ctl.now;
        end else if (ctl.kick && match) begin
            q_next.stamp = ctl.now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else begin
            q_reg <= q_next;
        end
    end

endmodule

/* rtl/wdt_expiry.sv */
// Expiry test at the head of the chain: wrapping age against timeout, restamp on expiry.
module wdt_expiry
    import wdt_pkg::*;
(
    input  wdt_entry_t head,
    input  logic [31:0] now,
    output logic        fire,
    output wdt_entry_t  restamped
);

    logic [31:0] age;

    assign age  = now - head.stamp;
    assign fire = (head.kind != KIND_DISABLED) && (head.stamp != 32'd0) && (age > head.tmo);

    always_comb begin
        restamped = head;
        if (fire) begin
            restamped.stamp = now;
        end
    end

endmodule

/* rtl/multi_channel_watchdog_table_top.sv */
// Watchdog channel table: add, remove, kick and tick over a row of SLOTS cells.
// One item at a time. Add and kick acks pass through ST_ACK into the output register, remove acks
// through ST_RFIND, ST_RSHIFT and ST_ACK; ST_ACK waits until the output register is free.
// A tick rotates the row once through the head expiry unit in ST_TICK, then ST_TFLUSH hands on
// the last expiry; the rotation stalls while the output register cannot take a pending expiry.
// The next item is accepted once the previous result sits in the output register.
// Synchronous reset clears the whole table and the channel count at once.
module multi_channel_watchdog_table_top
    import wdt_pkg::*;
#(
    parameter int SLOTS = WDT_SLOTS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // uptime_seconds[31:0], entry_id[63:32], watch_kind[65:64],
                                   // timeout_seconds[97:66], zero fill
    input  logic [1:0]   s_tuser,  // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,  // ok[0], fired_id[32:1], fired_kind[34:33], zero fill
    output logic         m_tuser,  // result_kind
    output logic         m_tlast
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TICK   = 3'd1;
    localparam logic [2:0] ST_TFLUSH = 3'd2;
    localparam logic [2:0] ST_RFIND  = 3'd3;
    localparam logic [2:0] ST_RSHIFT = 3'd4;
    localparam logic [2:0] ST_ACK    = 3'd5;

    logic [31:0] in_uptime;
    logic [31:0] in_id;
    logic [1:0]  in_kind;
    logic [31:0] in_tmo;
    logic        accept;

    logic [2:0]            state_reg, state_next;
    logic [SW-1:0]         step_reg, step_next;
    logic [WDT_NREP_W-1:0] nrep_reg, nrep_next;
    logic [31:0]           now_reg, now_next;
    logic [31:0]           id_reg, id_next;
    logic                  ack_ok_reg, ack_ok_next;
    logic [SLOTS-1:0]      match_reg, match_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [31:0]           pend_id_reg, pend_id_next;
    logic [1:0]            pend_kind_reg, pend_kind_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  o_kind_reg, o_kind_next;
    logic                  o_ok_reg, o_ok_next;
    logic [31:0]           o_id_reg, o_id_next;
    logic [1:0]            o_fkind_reg, o_fkind_next;
    logic                  o_last_reg, o_last_next;

    wdt_ctl_t   ctl;
    wdt_entry_t cell_q   [SLOTS];
    wdt_entry_t cell_nxt [SLOTS];
    logic [SLOTS-1:0] cell_match;
    logic [SLOTS-1:0] cell_load;
    logic [SLOTS-1:0] cell_add_here;
    logic [SLOTS-1:0] shift_sel;

    logic       fire;
    wdt_entry_t head_new;
    logic       o_free;
    logic       report;
    logic       need_push;
    logic       stall;

    assign in_uptime = s_tdata[31:0];
    assign in_id     = s_tdata[63:32];
    assign in_kind   = s_tdata[65:64];
    assign in_tmo    = s_tdata[97:66];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign o_free    = !m_valid_reg || m_tready;
    assign report    = fire && (nrep_reg < WDT_NREP_W'(WDT_MAX_RESULTS));
    assign need_push = report && pend_valid_reg;
    assign stall     = need_push && !o_free;

    always_comb begin
        ctl.add  = accept && (s_tuser == ACT_ADD) && (count_reg < CW'(SLOTS));
        ctl.kick = accept && (s_tuser == ACT_KICK);
        ctl.id   = (state_reg == ST_IDLE) ? in_id : id_reg;
        ctl.kind = in_kind;
        ctl.tmo  = in_tmo;
        ctl.now  = in_uptime;
    end

    wdt_expiry u_expiry (
        .head      (cell_q[0]),
        .now       (now_reg),
        .fire      (fire),
        .restamped (head_new)
    );

    // Prefix chain: every cell at or after the first match pulls from its right neighbour
    assign shift_sel[0] = match_reg[0];
    for (genvar g = 1; g < SLOTS; g++) begin : g_sel
        assign shift_sel[g] = shift_sel[g-1] | match_reg[g];
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        if (g < SLOTS - 1) begin : g_mid
            assign cell_nxt[g] = cell_q[g+1];
        end else begin : g_end
            // wrap the restamped head round during a tick, feed an empty slot on remove
            assign cell_nxt[g] = (state_reg == ST_TICK) ? head_new : '0;
        end

        assign cell_add_here[g] = (count_reg == CW'(g));
        assign cell_load[g]     = ((state_reg == ST_TICK) && !stall) ||
                                  ((state_reg == ST_RSHIFT) && shift_sel[g]);

        wdt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .load     (cell_load[g]),
            .add_here (cell_add_here[g]),
            .nxt_in   (cell_nxt[g]),
            .q        (cell_q[g]),
            .match    (cell_match[g])
        );
    end

    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        nrep_next       = nrep_reg;
        now_next        = now_reg;
        id_next         = id_reg;
        ack_ok_next     = ack_ok_reg;
        match_next      = match_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_kind_next  = pend_kind_reg;
        m_valid_next    = m_valid_reg;
        o_kind_next     = o_kind_reg;
        o_ok_next       = o_ok_reg;
        o_id_next       = o_id_reg;
        o_fkind_next    = o_fkind_reg;
        o_last_next     = o_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_tuser)
                        ACT_TICK: begin
                            now_next   = in_uptime;
                            step_next  = '0;
                            nrep_next  = '0;
                            state_next = ST_TICK;
                        end
                        ACT_ADD: begin
                            ack_ok_next = ctl.add;
                            if (ctl.add) begin
                                count_next = count_reg + CW'(1);
                            end
                            state_next = ST_ACK;
                        end
                        ACT_REMOVE: begin
                            id_next    = in_id;
                            state_next = ST_RFIND;
                        end
                        ACT_KICK: begin
                            ack_ok_next = 1'b1;
                            state_next  = ST_ACK;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RFIND: begin
                match_next = cell_match;
                state_next = ST_RSHIFT;
            end
            ST_RSHIFT: begin
                ack_ok_next = |match_reg;
                if (|match_reg) begin
                    count_next = count_reg - CW'(1);
                end
                state_next = ST_ACK;
            end
            ST_ACK: begin
                if (o_free) begin
                    m_valid_next = 1'b1;
                    o_kind_next  = RES_ACK;
                    o_ok_next    = ack_ok_reg;
                    o_id_next    = '0;
                    o_fkind_next = '0;
                    o_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (!stall) begin
                    // hand the held expiry on, it is not the final one
                    if (need_push) begin
                        m_valid_next = 1'b1;
                        o_kind_next  = RES_EXPIRY;
                        o_ok_next    = 1'b1;
                        o_id_next    = pend_id_reg;
                        o_fkind_next = pend_kind_reg;
                        o_last_next  = 1'b0;
                    end
                    if (report) begin
                        pend_valid_next = 1'b1;
                        pend_id_next    = cell_q[0].id;
                        pend_kind_next  = cell_q[0].kind;
                        nrep_next       = nrep_reg + WDT_NREP_W'(1);
                    end
                    step_next = step_reg + SW'(1);
                    if (step_reg == SW'(SLOTS - 1)) begin
                        step_next  = '0;
                        state_next = ST_TFLUSH;
                    end
                end
            end
            ST_TFLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (o_free) begin
                    m_valid_next    = 1'b1;
                    o_kind_next     = RES_EXPIRY;
                    o_ok_next       = 1'b1;
                    o_id_next       = pend_id_reg;
                    o_fkind_next    = pend_kind_reg;
                    o_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            nrep_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            match_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            nrep_reg       <= nrep_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            match_reg      <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg       <= now_next;
        id_reg        <= id_next;
        ack_ok_reg    <= ack_ok_next;
        pend_id_reg   <= pend_id_next;
        pend_kind_reg <= pend_kind_next;
        o_kind_reg    <= o_kind_next;
        o_ok_reg      <= o_ok_next;
        o_id_reg      <= o_id_next;
        o_fkind_reg   <= o_fkind_next;
        o_last_reg    <= o_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, o_fkind_reg, o_id_reg, o_ok_reg};
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;

endmodule

/* rtl/wdt_checker.sv */
// Port-level checks on the watchdog table, bound to the top level.
module wdt_checker
    import wdt_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [39:0]  m_tdata,
    input logic         m_tuser,
    input logic         m_tlast
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result beat changed");

    // one item at a time: no second beat straight after an accepted one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in progress");

    // acks are single-beat with empty expiry fields
    a_ack_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == RES_ACK) |-> m_tlast && (m_tdata[34:1] == 34'd0))
        else $error("malformed acknowledgement");

    // expiries always succeed and name an enabled channel
    a_expiry_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == RES_EXPIRY) |-> m_tdata[0] && (m_tdata[34:33] != KIND_DISABLED))
        else $error("malformed expiry");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result beat right after reset");

endmodule

bind multi_channel_watchdog_table_top wdt_checker u_wdt_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the watchdog channel table: directed and random table traffic.
module tb_top;
    import wdt_pkg::*;

    localparam int SLOTS = WDT_SLOTS;

    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [31:0] fired_id;
        logic [1:0]  fired_kind;
        logic        last;
    } wdt_result_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;  // uptime_seconds[31:0], entry_id[63:32], watch_kind[65:64],
                            // timeout_seconds[97:66], zero fill
    logic [1:0]   s_tuser;  // action
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;  // ok[0], fired_id[32:1], fired_kind[34:33], zero fill
    logic         m_tuser;  // result_kind
    logic         m_tlast;

    // Predicted table contents
    logic [31:0] tbl_ids    [SLOTS] = '{default: '0};
    logic [1:0]  tbl_kinds  [SLOTS] = '{default: '0};
    logic [31:0] tbl_tmo    [SLOTS] = '{default: '0};
    logic [31:0] tbl_stamps [SLOTS] = '{default: '0};
    int          tbl_count = 0;

    wdt_result_t pending_results[$];

    int  errors = 0;
    int  n_sent[4] = '{default: 0};
    int  n_expiries = 0;
    int  n_acks = 0;
    bit  src_calm = 1'b0;
    bit  sink_calm = 1'b0;

    multi_channel_watchdog_table_top #(.SLOTS(SLOTS)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Work out the results of one accepted beat and update the table copy
    task automatic predict_table_op(input logic [1:0] act, input logic [31:0] now,
                                    input logic [31:0] id, input logic [1:0] kind,
                                    input logic [31:0] tmo);
        wdt_result_t res;
        int          n_fired;
        int          pos;
        logic        ok;
        n_fired = 0;
        pos = tbl_count;
        ok = 1'b0;
        res = '0;
        case (act)
            ACT_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_kinds[i] != KIND_DISABLED && tbl_stamps[i] != 32'd0 &&
                        (now - tbl_stamps[i]) > tbl_tmo[i]) begin
                        if (n_fired < WDT_MAX_RESULTS) begin
                            res = '{RES_EXPIRY, 1'b1, tbl_ids[i], tbl_kinds[i], 1'b0};
                            pending_results.push_back(res);
                            n_fired++;
                        end
                        tbl_stamps[i] = now;
                    end
                end
                if (n_fired > 0)
                    pending_results[pending_results.size() - 1].last = 1'b1;
            end
            ACT_ADD: begin
                if (tbl_count < SLOTS) begin
                    tbl_ids[tbl_count]    = id;
                    tbl_kinds[tbl_count]  = kind;
                    tbl_tmo[tbl_count]    = tmo;
                    tbl_stamps[tbl_count] = now;
                    tbl_count++;
                    ok = 1'b1;
                end
                pending_results.push_back('{RES_ACK, ok, 32'd0, 2'd0, 1'b1});
            end
            ACT_REMOVE: begin
                for (int i = tbl_count - 1; i >= 0; i--)
                    if (tbl_ids[i] == id) pos = i;
                if (pos < tbl_count) begin
                    // close the gap and clear the freed tail slot
                    for (int i = pos; i < tbl_count - 1; i++) begin
                        tbl_ids[i]    = tbl_ids[i + 1];
                        tbl_kinds[i]  = tbl_kinds[i + 1];
                        tbl_tmo[i]    = tbl_tmo[i + 1];
                        tbl_stamps[i] = tbl_stamps[i + 1];
                    end
                    tbl_count--;
                    tbl_ids[tbl_count]    = '0;
                    tbl_kinds[tbl_count]  = KIND_DISABLED;
                    tbl_tmo[tbl_count]    = '0;
                    tbl_stamps[tbl_count] = '0;
                    ok = 1'b1;
                end
                pending_results.push_back('{RES_ACK, ok, 32'd0, 2'd0, 1'b1});
            end
            default: begin
                for (int i = 0; i < tbl_count; i++)
                    if (tbl_ids[i] == id) tbl_stamps[i] = now;
                pending_results.push_back('{RES_ACK, 1'b1, 32'd0, 2'd0, 1'b1});
            end
        endcase
    endtask

    // Drive one beat on the input channel; called and returns at a falling edge
    task automatic send_item(input logic [1:0] act, input logic [31:0] now,
                             input logic [31:0] id, input logic [1:0] kind,
                             input logic [31:0] tmo);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {6'd0, tmo, kind, id, now};
        s_tuser  = act;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_table_op(act, now, id, kind, tmo);
        n_sent[act]++;
        @(negedge aclk);
    endtask

    task automatic check_result();
        wdt_result_t exp_res;
        wdt_result_t got;
        got = '{m_tuser, m_tdata[0], m_tdata[32:1], m_tdata[34:33], m_tlast};
        if (m_tuser == RES_EXPIRY) n_expiries++;
        else n_acks++;
        if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("[%0t] unexpected result: kind %0b ok %0b id %h fkind %0d last %0b",
                         $time, got.kind, got.ok, got.fired_id, got.fired_kind, got.last);
        end else begin
            exp_res = pending_results.pop_front();
            if (got !== exp_res) begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] mismatch: exp kind %0b ok %0b id %h fkind %0d last %0b, got kind %0b ok %0b id %h fkind %0d last %0b",
                             $time, exp_res.kind, exp_res.ok, exp_res.fired_id,
                             exp_res.fired_kind, exp_res.last, got.kind, got.ok,
                             got.fired_id, got.fired_kind, got.last);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result();
    end

    // Result side: draw a stall before every beat
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = sink_calm ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    task automatic test_empty_table();
        send_item(ACT_TICK, 32'd5, 32'd7, 2'd1, 32'd0);
        send_item(ACT_REMOVE, 32'd5, 32'd7, 2'd0, 32'd0);
        send_item(ACT_KICK, 32'd5, 32'd7, 2'd0, 32'd0);
    endtask

    task automatic test_fill_table();
        // zero stamp on the first channel, extreme id and timeout on the second
        send_item(ACT_ADD, 32'd0, 32'd0, 2'd1, 32'd0);
        send_item(ACT_ADD, 32'd10, 32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
        send_item(ACT_ADD, 32'd10, 32'd5, KIND_DISABLED, 32'd1);
        send_item(ACT_ADD, 32'd10, 32'd5, 2'd2, 32'd3);
        send_item(ACT_ADD, 32'd10, 32'd9, 2'd1, 32'd2);
        send_item(ACT_ADD, 32'd10, 32'd10, 2'd2, 32'd0);
        send_item(ACT_ADD, 32'd10, 32'd11, 2'd3, 32'd5);
        send_item(ACT_ADD, 32'd10, 32'd12, 2'd1, 32'd1);
        send_item(ACT_ADD, 32'd10, 32'd13, 2'd1, 32'd1);
    endtask

    task automatic test_expiry_rules();
        // age equal to timeout holds, strictly larger fires
        send_item(ACT_TICK, 32'd12, 32'd0, 2'd0, 32'd0);
        send_item(ACT_TICK, 32'd13, 32'd0, 2'd0, 32'd0);
        send_item(ACT_KICK, 32'd20, 32'd0, 2'd0, 32'd0);
        send_item(ACT_KICK, 32'd20, 32'd5, 2'd0, 32'd0);
        send_item(ACT_TICK, 32'd40, 32'd0, 2'd0, 32'd0);
    endtask

    task automatic test_remove_shift();
        send_item(ACT_REMOVE, 32'd41, 32'd5, 2'd0, 32'd0);
        send_item(ACT_REMOVE, 32'd41, 32'd99, 2'd0, 32'd0);
        send_item(ACT_REMOVE, 32'd41, 32'hFFFF_FFFF, 2'd0, 32'd0);
        send_item(ACT_TICK, 32'd100, 32'd0, 2'd0, 32'd0);
    endtask

    task automatic test_wrap_age();
        send_item(ACT_KICK, 32'hFFFF_FFFF, 32'd9, 2'd0, 32'd0);
        send_item(ACT_TICK, 32'd1, 32'd0, 2'd0, 32'd0);
        send_item(ACT_TICK, 32'd2, 32'd0, 2'd0, 32'd0);
    endtask

    // Mostly well-formed table traffic on a running uptime, with some noise
    task automatic run_table_traffic(input int n_ops, input logic [31:0] start_time);
        logic [31:0] wall;
        logic [31:0] id;
        logic [31:0] tmo;
        logic [31:0] id_pool[6];
        logic [1:0]  kind;
        int          roll;
        wall = start_time;
        id_pool = '{32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, $urandom};
        for (int k = 0; k < n_ops; k++) begin
            if (k % 25 == 0) begin
                src_calm  = ($urandom_range(0, 3) == 0);
                sink_calm = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (tbl_count > 0 && $urandom_range(0, 3) != 0)
                id = tbl_ids[$urandom_range(0, tbl_count - 1)];
            else
                id = id_pool[$urandom_range(0, 5)];
            kind = 2'($urandom_range(0, 3));
            tmo  = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 12));
            if ($urandom_range(0, 39) == 0) wall = $urandom;
            wall += 32'($urandom_range(0, 3));
            if (roll < 35)
                send_item(ACT_TICK, wall, $urandom, kind, $urandom);
            else if (roll < 53)
                send_item(ACT_ADD, wall, id, kind, tmo);
            else if (roll < 70)
                send_item(ACT_KICK, wall, id, kind, tmo);
            else if (roll < 87)
                send_item(ACT_REMOVE, wall, id, kind, tmo);
            else
                send_item(2'($urandom_range(0, 3)), $urandom, $urandom,
                          2'($urandom_range(0, 3)), $urandom);
        end
    endtask

    task automatic test_random_traffic();
        run_table_traffic(130, 32'd1);
    endtask

    task automatic test_uptime_wrap();
        run_table_traffic(80, 32'hFFFF_FFA0);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_TICK;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_empty_table();
        test_fill_table();
        test_expiry_rules();
        test_remove_shift();
        test_wrap_age();
        test_random_traffic();
        test_uptime_wrap();

        s_tvalid = 1'b0;
        sink_calm = 1'b1;
        while (pending_results.size() > 0) @(posedge aclk);
        // let a final tick scan drain in case it fires late
        repeat (4 * SLOTS + 20) @(posedge aclk);
        if (pending_results.size() > 0) begin
            errors += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end

        $display("Sent %0d ticks, %0d adds, %0d removes, %0d kicks",
                 n_sent[ACT_TICK], n_sent[ACT_ADD], n_sent[ACT_REMOVE], n_sent[ACT_KICK]);
        $display("Checked %0d acknowledgements and %0d expiry beats, %0d errors",
                 n_acks, n_expiries, errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
